// ===== sv/gfm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfm_pkg
// Shared type, constants and function of the GCM GF(2^128) multiplier.
// ----------------------------------------------------------------------------
package gfm_pkg;

   // Width of one field element and of one half of it.
   localparam int FIELD_BITS = 128;
   localparam int HALF_BITS  = 64;

   // Reduction constant 0xE1 placed at bits 0-7 in GCM order, which is the
   // top byte of the 128-bit vector.
   localparam logic [FIELD_BITS-1:0] REDUCE_POLY = {8'hE1, 120'd0};

   // Work carried from one pipeline stage to the next: the partial product,
   // the running multiple of the first operand and the bits of the second
   // operand still to be consumed, next bit at the top.
   typedef struct packed {
      logic [FIELD_BITS-1:0] z;
      logic [FIELD_BITS-1:0] v;
      logic [FIELD_BITS-1:0] b;
   } gfm_work_type;

   // Multiply by x: shift one place toward bit 127 and fold the bit that
   // leaves back in through the reduction polynomial.
   function automatic logic [FIELD_BITS-1:0] gfm_times_x(input logic [FIELD_BITS-1:0] v);
      logic [FIELD_BITS-1:0] shifted;
      shifted = {1'b0, v[FIELD_BITS-1:1]};
      return v[0] ? (shifted ^ REDUCE_POLY) : shifted;
   endfunction

endpackage : gfm_pkg
`default_nettype wire

// ===== sv/gfm_channels.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfm_req_if / gfm_rsp_if
// Valid/ready channels for the operand items and the product items.
// ----------------------------------------------------------------------------
interface gfm_req_if;
   logic                           valid;
   logic                           ready;
   logic [gfm_pkg::HALF_BITS-1:0]  a_high;
   logic [gfm_pkg::HALF_BITS-1:0]  a_low;
   logic [gfm_pkg::HALF_BITS-1:0]  b_high;
   logic [gfm_pkg::HALF_BITS-1:0]  b_low;

   modport source (output valid, output a_high, output a_low, output b_high,
                   output b_low, input ready);
   modport sink   (input valid, input a_high, input a_low, input b_high,
                   input b_low, output ready);
endinterface : gfm_req_if

interface gfm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gfm_pkg::HALF_BITS-1:0]  product_high;
   logic [gfm_pkg::HALF_BITS-1:0]  product_low;

   modport source (output valid, output product_high, output product_low,
                   input ready);
   modport sink   (input valid, input product_high, input product_low,
                   output ready);
endinterface : gfm_rsp_if
`default_nettype wire

// ===== sv/gf128_multiply.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gf128_multiply
// Pipelined GF(2^128) multiplier in the GCM bit convention (GHASH multiply),
// reduction polynomial x^128 + x^7 + x^2 + x + 1.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                             Handshake
//   req_bus   in         a_high, a_low, b_high, b_low        valid / ready
//   rsp_bus   out        product_high, product_low           valid / ready
//
// One item may enter every cycle unless the input stalls; its product passes
// through the stage registers in order, one stage per group of operand
// bits. The throughput of one item per cycle is set by the stage chain.
// Reset clears only the stage valid bits; payload registers are not reset.
// When the result is not taken, items close up behind it into empty stages,
// and the input stalls only when every stage holds an item.
//
module gf128_multiply #(
   // Operand bits handled in one stage; a power of two from 1 to 64.
   parameter int STEPS_PER_STAGE = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   gfm_req_if.sink    req_bus,
   gfm_rsp_if.source  rsp_bus
);
   import gfm_pkg::*;

   localparam int STAGES = FIELD_BITS / STEPS_PER_STAGE;

   // Handshake and payload between stages; index s is the input of stage s,
   // and index STAGES is the output of the last stage.
   logic         stage_valid [STAGES+1];
   logic         stage_ready [STAGES+1];
   gfm_work_type stage_data  [STAGES+1];
   logic [STAGES-1:0] held;

   // The first stage starts from a zero product, the first operand as the
   // running multiple and the whole second operand with bit 0 on top.
   assign stage_valid[0]  = req_bus.valid;
   assign req_bus.ready   = stage_ready[0];
   assign stage_data[0].z = '0;
   assign stage_data[0].v = {req_bus.a_high, req_bus.a_low};
   assign stage_data[0].b = {req_bus.b_high, req_bus.b_low};

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      gfm_stage #(
         .STEPS(STEPS_PER_STAGE)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[s]),
         .in_ready  (stage_ready[s]),
         .in_data   (stage_data[s]),
         .out_valid (stage_valid[s+1]),
         .out_ready (stage_ready[s+1]),
         .out_data  (stage_data[s+1])
      );
      assign held[s] = stage_valid[s+1];
   end

   // The last stage register is the output register.
   assign rsp_bus.valid        = stage_valid[STAGES];
   assign stage_ready[STAGES]  = rsp_bus.ready;
   assign rsp_bus.product_high = stage_data[STAGES].z[FIELD_BITS-1:HALF_BITS];
   assign rsp_bus.product_low  = stage_data[STAGES].z[HALF_BITS-1:0];

`ifndef ASSERT_OFF
   // An accepted item is held by the first stage in the next cycle.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> held[0])
      else $error("accepted item did not enter the first stage");

   // The input stalls only when every stage holds an item.
   a_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (&held))
      else $error("input stalled with an empty stage");

   // An item in front of an empty stage moves into it.
   a_close: assert property (@(posedge clock) disable iff (reset)
      ((held[STAGES-2:0] & ~held[STAGES-1:1]) != '0) |=>
      ((held[STAGES-1:1] & $past(held[STAGES-2:0] & ~held[STAGES-1:1]))
         == $past(held[STAGES-2:0] & ~held[STAGES-1:1])))
      else $error("item failed to advance into an empty stage");

   // Nothing is held after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> (held == '0))
      else $error("stage valid bits not cleared by reset");
`endif

endmodule : gf128_multiply
`default_nettype wire

// ===== sv/gfm_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfm_stage
// One registered pipeline stage: consumes STEPS bits of the second operand,
// accumulating and stepping the running multiple, with a valid/ready hold.
// ----------------------------------------------------------------------------
module gfm_stage #(
   parameter int STEPS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire gfm_pkg::gfm_work_type in_data,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      gfm_pkg::gfm_work_type out_data
);
   import gfm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   gfm_work_type data_ff;
   gfm_work_type data_in;
   logic         take;

   // The stage can take an item when it is empty or its item leaves now.
   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      logic [FIELD_BITS-1:0] z;
      logic [FIELD_BITS-1:0] v;
      z = in_data.z;
      v = in_data.v;
      for (int k = 0; k < STEPS; k++) begin
         if (in_data.b[FIELD_BITS-1-k]) begin
            z = z ^ v;
         end
         v = gfm_times_x(v);
      end
      data_in.z = z;
      data_in.v = v;
      data_in.b = in_data.b << STEPS;
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule : gfm_stage
`default_nettype wire
